[sv/desf_pkg.sv]
// desf_pkg: shared types and constants for the damped edge spring force block.
// No dependencies.
package desf_pkg;

   localparam int MaxVertices = 1024;
   localparam int EdgeLimit   = (MaxVertices - 1 < 1023) ? MaxVertices - 1 : 1023;

   localparam logic CSR_STIFFNESS = 1'b0;
   localparam logic CSR_DAMPING   = 1'b1;

   localparam logic [31:0] STIFFNESS_RESET = 32'd65536;

   // edge job handed from front to back
   typedef struct packed {
      logic signed [33:0] e_x;
      logic signed [33:0] e_y;
      logic signed [33:0] e_z;
      logic signed [33:0] r_x;
      logic signed [33:0] r_y;
      logic signed [33:0] r_z;
      logic signed [33:0] d_x;
      logic signed [33:0] d_y;
      logic signed [33:0] d_z;
      logic [9:0]         idx;
   } edge_job_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic [9:0]         edge_index;
      logic               saturated;
      logic               zero_length;
   } edge_rsp_type;

endpackage

[sv/desf_front.sv]
// desf_front: accepts vertices, keeps the previous one, emits edge jobs.
// Depends on desf_pkg.
module desf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [287:0]          in_data,
   input  logic                  in_first,
   output logic                  job_valid,
   input  logic                  job_ready,
   output desf_pkg::edge_job_type job
);
   import desf_pkg::*;

   logic [95:0] prev_pos_ff, prev_pos_in;
   logic [95:0] prev_rest_ff, prev_rest_in;
   logic [95:0] prev_vel_ff, prev_vel_in;
   logic        have_prev_ff, have_prev_in;
   logic [9:0]  cnt_ff, cnt_in;
   logic        fire, is_first, drop;

   function automatic logic signed [33:0] sub32(input logic [31:0] a, input logic [31:0] b);
      sub32 = 34'(signed'(a)) - 34'(signed'(b));
   endfunction

   assign in_ready  = job_ready;
   assign fire      = in_valid && in_ready;
   assign is_first  = in_first || !have_prev_ff;
   assign drop      = 32'(cnt_ff) >= 32'(EdgeLimit);
   assign job_valid = fire && !is_first && !drop;

   always_comb begin
      job.e_x = sub32(in_data[31:0],    prev_pos_ff[31:0]);
      job.e_y = sub32(in_data[63:32],   prev_pos_ff[63:32]);
      job.e_z = sub32(in_data[95:64],   prev_pos_ff[95:64]);
      job.r_x = sub32(in_data[127:96],  prev_rest_ff[31:0]);
      job.r_y = sub32(in_data[159:128], prev_rest_ff[63:32]);
      job.r_z = sub32(in_data[191:160], prev_rest_ff[95:64]);
      job.d_x = sub32(in_data[223:192], prev_vel_ff[31:0]);
      job.d_y = sub32(in_data[255:224], prev_vel_ff[63:32]);
      job.d_z = sub32(in_data[287:256], prev_vel_ff[95:64]);
      job.idx = cnt_ff;
   end

   always_comb begin
      prev_pos_in  = prev_pos_ff;
      prev_rest_in = prev_rest_ff;
      prev_vel_in  = prev_vel_ff;
      have_prev_in = have_prev_ff;
      cnt_in       = cnt_ff;
      if (fire && (is_first || !drop)) begin
         prev_pos_in  = in_data[95:0];
         prev_rest_in = in_data[191:96];
         prev_vel_in  = in_data[287:192];
         have_prev_in = 1'b1;
         cnt_in       = is_first ? 10'd0 : cnt_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff  <= '0;
         prev_rest_ff <= '0;
         prev_vel_ff  <= '0;
         have_prev_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         prev_pos_ff  <= prev_pos_in;
         prev_rest_ff <= prev_rest_in;
         prev_vel_ff  <= prev_vel_in;
         have_prev_ff <= have_prev_in;
         cnt_ff       <= cnt_in;
      end
   end
endmodule

[sv/desf_queue.sv]
// desf_queue: two-entry queue of edge jobs between front and back.
// Depends on desf_pkg.
module desf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  desf_pkg::edge_job_type wr_job,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output desf_pkg::edge_job_type rd_job
);
   import desf_pkg::*;

   edge_job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_wr, do_rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_job   = mem_ff[rp_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= ~wp_ff;
         if (do_rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(do_wr) - 2'(do_rd);
      end
   end
endmodule

[sv/desf_back.sv]
// desf_back: sequenced force computation for one edge: per-component multipliers,
// bit-serial sqrt and divider. Depends on desf_pkg.
module desf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  desf_pkg::edge_job_type job,
   input  logic [31:0]           stiffness,
   input  logic [31:0]           damping,
   output logic                  out_valid,
   input  logic                  out_ready,
   output desf_pkg::edge_rsp_type out_rsp
);
   import desf_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_SQ = 4'd1, ST_SQRT = 4'd2, ST_DOT = 4'd3,
                          ST_PDIV = 4'd4, ST_T = 4'd5, ST_FMUL = 4'd6, ST_FDIV = 4'd7,
                          ST_OUT = 4'd8;

   logic [3:0]  st_ff;
   edge_job_type j_ff;
   logic [1:0]  k_ff;               // component / step counter
   logic [7:0]  it_ff;              // serial iteration counter
   logic [66:0] se_ff, sr_ff;       // squared lengths
   logic [33:0] le_ff, lr_ff;       // lengths
   logic [67:0] srem_e_ff, srem_r_ff;
   logic [66:0] sq_e_ff, sq_r_ff;   // shifting radicands
   logic [68:0] dot_ff;             // signed dot product
   logic [127:0] n_ff;              // dividend/quotient shift register
   logic [63:0] rem_ff;
   logic [63:0] den_ff;
   logic [33:0] pr_ff;
   logic        pr_neg_ff;
   logic [68:0] t_ff;               // signed scalar, 2^-16 units
   logic signed [31:0] f_ff [3];
   logic        sat_ff;
   logic        ovalid_ff;
   edge_rsp_type orsp_ff;

   // products are taken one component at a time, on magnitudes
   function automatic logic [33:0] mag34(input logic signed [33:0] v);
      mag34 = v[33] ? 34'(-v) : 34'(v);
   endfunction

   logic signed [33:0] ce, cr, cd;
   always_comb begin
      unique case (k_ff)
         2'd0:    begin ce = j_ff.e_x; cr = j_ff.r_x; cd = j_ff.d_x; end
         2'd1:    begin ce = j_ff.e_y; cr = j_ff.r_y; cd = j_ff.d_y; end
         default: begin ce = j_ff.e_z; cr = j_ff.r_z; cd = j_ff.d_z; end
      endcase
   end

   logic [33:0] ce_mag, cr_mag, cd_mag;
   assign ce_mag = mag34(ce);
   assign cr_mag = mag34(cr);
   assign cd_mag = mag34(cd);

   logic [67:0] sq_e, sq_r, dprod;
   assign sq_e  = {34'd0, ce_mag} * {34'd0, ce_mag};
   assign sq_r  = {34'd0, cr_mag} * {34'd0, cr_mag};
   assign dprod = {34'd0, cd_mag} * {34'd0, ce_mag};

   // restoring sqrt step (two bits of radicand a cycle)
   function automatic logic [101:0] sqstep(input logic [67:0] rem, input logic [33:0] root,
                                           input logic [1:0] bits);
      logic [67:0] r2, trial;
      r2    = {rem[65:0], bits};
      trial = {32'd0, root, 2'b01};
      if (r2 >= trial) sqstep = {r2 - trial, root[32:0], 1'b1};
      else             sqstep = {r2, root[32:0], 1'b0};
   endfunction

   logic [101:0] sqe_n, sqr_n;
   assign sqe_n = sqstep(srem_e_ff, le_ff, sq_e_ff[66:65]);
   assign sqr_n = sqstep(srem_r_ff, lr_ff, sq_r_ff[66:65]);

   // restoring divide step
   logic [64:0] drem2;
   logic        dge;
   assign drem2 = {rem_ff, n_ff[127]};
   assign dge   = drem2 >= {1'b0, den_ff};

   logic [68:0] dot_mag;
   assign dot_mag = dot_ff[68] ? -dot_ff : dot_ff;

   logic signed [33:0] diff;
   logic [33:0] diff_mag;
   logic [65:0] kprod, cprod;
   assign diff     = 34'($signed({1'b0, le_ff}) - $signed({1'b0, lr_ff}));
   assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
   assign kprod    = {34'd0, stiffness} * {32'd0, diff_mag};
   assign cprod    = {32'd0, pr_ff} * {34'd0, damping};

   // |T| stays below 2^67, so two 34-bit slices cover it
   logic        tneg;
   logic [67:0] tmag;
   logic [33:0] tchunk;
   logic [67:0] fmul;
   assign tneg   = t_ff[68];
   assign tmag   = 68'(tneg ? -t_ff : t_ff);
   assign tchunk = it_ff[0] ? tmag[67:34] : tmag[33:0];
   assign fmul   = {34'd0, tchunk} * {34'd0, ce_mag};

   logic [127:0] fq;
   logic         fneg;
   logic [31:0]  flim;
   assign fq   = {n_ff[126:0], dge};
   assign fneg = tneg ^ ce[33];
   assign flim = fneg ? 32'h8000_0000 : 32'h7FFF_FFFF;

   logic load_out;
   assign load_out = (st_ff == ST_OUT) && (!ovalid_ff || out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (load_out) ovalid_ff <= 1'b1;
         else if (out_valid && out_ready) ovalid_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: if (job_valid) begin
               j_ff <= job; k_ff <= 2'd0; se_ff <= '0; sr_ff <= '0; dot_ff <= '0;
               st_ff <= ST_SQ;
            end
            ST_SQ: begin
               se_ff  <= se_ff + 67'(sq_e);
               sr_ff  <= sr_ff + 67'(sq_r);
               dot_ff <= (cd[33] ^ ce[33]) ? dot_ff - 69'(dprod) : dot_ff + 69'(dprod);
               if (k_ff == 2'd2) begin
                  k_ff <= 2'd0; it_ff <= '0;
                  le_ff <= '0; lr_ff <= '0; srem_e_ff <= '0; srem_r_ff <= '0;
                  st_ff <= ST_SQRT;
               end else k_ff <= k_ff + 2'd1;
            end
            ST_SQRT: begin
               if (it_ff == 8'd0) begin
                  sq_e_ff <= {se_ff[65:0], 1'b0} ; // align: 68 bits -> 34 pairs
                  sq_r_ff <= {sr_ff[65:0], 1'b0};
                  srem_e_ff <= 68'(se_ff[66]); srem_r_ff <= 68'(sr_ff[66]);
                  le_ff <= 34'(se_ff[66]); lr_ff <= 34'(sr_ff[66]);
                  it_ff <= 8'd1;
               end else begin
                  srem_e_ff <= sqe_n[101:34]; le_ff <= sqe_n[33:0];
                  srem_r_ff <= sqr_n[101:34]; lr_ff <= sqr_n[33:0];
                  sq_e_ff <= {sq_e_ff[64:0], 2'b00};
                  sq_r_ff <= {sq_r_ff[64:0], 2'b00};
                  if (it_ff == 8'd33) st_ff <= ST_DOT;
                  it_ff <= it_ff + 8'd1;
               end
            end
            ST_DOT: begin
               if (se_ff == '0) begin
                  st_ff <= ST_OUT;
               end else begin
                  pr_neg_ff <= dot_ff[68];
                  n_ff   <= {59'd0, dot_mag};
                  rem_ff <= '0; den_ff <= {30'd0, le_ff}; it_ff <= '0;
                  st_ff  <= ST_PDIV;
               end
            end
            ST_PDIV: begin
               rem_ff <= dge ? 64'(drem2 - {1'b0, den_ff}) : drem2[63:0];
               n_ff   <= {n_ff[126:0], dge};
               if (it_ff == 8'd127) begin
                  k_ff <= 2'd0; st_ff <= ST_T;
               end
               it_ff <= it_ff + 8'd1;
            end
            ST_T: begin
               if (k_ff == 2'd0) begin
                  pr_ff <= n_ff[33:0];
                  t_ff  <= diff[33] ? -{3'd0, kprod} : {3'd0, kprod};
                  k_ff  <= 2'd1;
               end else begin
                  t_ff <= pr_neg_ff ? t_ff - {3'd0, cprod} : t_ff + {3'd0, cprod};
                  k_ff <= 2'd0; it_ff <= '0; sat_ff <= 1'b0;
                  st_ff <= ST_FMUL;
               end
            end
            ST_FMUL: begin
               // |T| * |e_k|, low slice then high slice
               if (it_ff == 8'd0) begin
                  n_ff  <= {60'd0, fmul};
                  it_ff <= 8'd1;
               end else begin
                  n_ff   <= n_ff + {26'd0, fmul, 34'd0};
                  rem_ff <= '0; den_ff <= {14'd0, le_ff, 16'd0}; it_ff <= '0;
                  st_ff  <= ST_FDIV;
               end
            end
            ST_FDIV: begin
               rem_ff <= dge ? 64'(drem2 - {1'b0, den_ff}) : drem2[63:0];
               n_ff   <= fq;
               if (it_ff != 8'd127) begin
                  it_ff <= it_ff + 8'd1;
               end else begin
                  if (fq > {96'd0, flim}) begin
                     f_ff[k_ff] <= fneg ? $signed(-flim) : $signed(flim); sat_ff <= 1'b1;
                  end else f_ff[k_ff] <= fneg ? $signed(-fq[31:0]) : $signed(fq[31:0]);
                  if (k_ff == 2'd2) begin
                     st_ff <= ST_OUT;
                  end else begin
                     k_ff <= k_ff + 2'd1; it_ff <= '0; st_ff <= ST_FMUL;
                  end
               end
            end
            default: begin // ST_OUT
               if (load_out) begin
                  if (se_ff == '0)
                     orsp_ff <= '{force_x: '0, force_y: '0, force_z: '0,
                                  edge_index: j_ff.idx, saturated: 1'b0, zero_length: 1'b1};
                  else
                     orsp_ff <= '{force_x: f_ff[0], force_y: f_ff[1], force_z: f_ff[2],
                                  edge_index: j_ff.idx, saturated: sat_ff, zero_length: 1'b0};
                  st_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign job_ready = st_ff == ST_IDLE;
   assign out_valid = ovalid_ff;
   assign out_rsp   = orsp_ff;
endmodule

[sv/damped_edge_spring_force.sv]
// damped_edge_spring_force: top level; front end, job queue, back end, CSRs.
// Depends on desf_pkg, desf_front, desf_queue, desf_back.
//
//  channel | dir | payload
//  req_    | in  | tdata: pos xyz, rest xyz, vel xyz; tuser: first_vertex
//  rsp_    | out | tdata: force xyz, edge_index; tuser: saturated, zero_length
//  csr_    | in  | wen, index, 32-bit data
//
// A vertex is taken by the front end; an edge job then runs through the back end
// (34-step sqrt, a 128-step divider for the projection and one for each of three
// force components, two multiply steps per component); a zero-length edge skips
// the dividers and multiply steps. Two jobs queue. Reset is synchronous and clears
// state, control and damping; stiffness resets to 65536. Either side may stall; the
// result register holds until taken.
module damped_edge_spring_force (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [287:0]  req_tdata,   // pos_x,pos_y,pos_z,rest_x..z,vel_x..z
   input  logic          req_tuser,   // first_vertex
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // force_x,force_y,force_z,edge_index,pad
   output logic [1:0]    rsp_tuser,   // saturated, zero_length
   input  logic          csr_wen,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);
   import desf_pkg::*;

   logic [31:0] k_ff, c_ff;
   logic        fj_valid, fj_ready, qj_valid, qj_ready;
   edge_job_type fj, qj;
   edge_rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= STIFFNESS_RESET;
         c_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_STIFFNESS: k_ff <= csr_wdata;
            default:       c_ff <= csr_wdata;
         endcase
      end
   end

   desf_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .in_first(req_tuser),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

   desf_queue u_queue (
      .clock, .reset, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
      .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj));

   desf_back u_back (
      .clock, .reset, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
      .stiffness(k_ff), .damping(c_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp));

   assign rsp_tdata = {6'd0, rsp.edge_index, rsp.force_z, rsp.force_y, rsp.force_x};
   assign rsp_tuser = {rsp.zero_length, rsp.saturated};
endmodule

[test/desf_checker.sv]
// desf_checker: watches the request, response and CSR ports of the spring force block,
// predicts every edge force and compares it with what comes out.
// Depends on desf_pkg.
`timescale 1ns / 100ps

module desf_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [287:0]  req_tdata,
   input  logic          req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [111:0]  rsp_tdata,
   input  logic [1:0]    rsp_tuser,
   input  logic          csr_wen,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata,
   output int            fail_count,
   output int            pending
);
   import desf_pkg::*;

   logic [31:0]  stiffness;
   logic [31:0]  damping;
   longint       last_pos [3];
   longint       last_rest [3];
   longint       last_vel [3];
   bit           have_last;
   int unsigned  edge_count;
   edge_rsp_type force_queue [$];

   function automatic logic [63:0] floor_root(input logic [127:0] s);
      logic [63:0]  res;
      logic [63:0]  cand;
      res = 0;
      for (int b = 33; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= s) res = cand;
      end
      return res;
   endfunction

   function automatic logic [63:0] mag(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // force on one edge from edge, rest edge and velocity difference
   function automatic edge_rsp_type edge_force(input longint e [3], input longint re [3],
                                               input longint dv [3], input logic [9:0] idx);
      edge_rsp_type       res;
      logic [127:0]       se;
      logic [127:0]       sr;
      logic [63:0]        len_e;
      logic [63:0]        len_r;
      longint             diff;
      logic signed [159:0] dot;
      logic signed [159:0] ta;
      logic signed [159:0] tb;
      logic signed [159:0] tsum;
      logic [159:0]       dot_mag;
      logic [159:0]       proj;
      logic [159:0]       tmag;
      logic [159:0]       prod;
      logic [159:0]       quo;
      logic [159:0]       den;
      logic [159:0]       lim;
      logic               neg;
      logic [31:0]        comp [3];
      se = 0;
      sr = 0;
      dot = 0;
      res = '0;
      res.edge_index = idx;
      for (int i = 0; i < 3; i++) begin
         se += {64'd0, mag(e[i])} * {64'd0, mag(e[i])};
         sr += {64'd0, mag(re[i])} * {64'd0, mag(re[i])};
         ta = e[i];
         tb = dv[i];
         dot += ta * tb;
      end
      if (se == 0) begin
         res.zero_length = 1'b1;
         return res;
      end
      len_e = floor_root(se);
      len_r = floor_root(sr);
      diff = longint'(len_e) - longint'(len_r);
      ta = {128'd0, stiffness} * {96'd0, mag(diff)};
      if (diff < 0) ta = -ta;
      dot_mag = (dot < 0) ? -dot : dot;
      proj = {96'd0, 64'(dot_mag / {96'd0, len_e})};
      tb = {128'd0, damping} * proj;
      if (dot < 0) tb = -tb;
      tsum = ta + tb;
      tmag = (tsum < 0) ? -tsum : tsum;
      den = {96'd0, len_e} << 16;
      res.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         neg = (tsum < 0) != (e[i] < 0);
         lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
         prod = tmag * {96'd0, mag(e[i])};
         quo = prod / den;
         if (quo > lim) begin
            quo = lim;
            res.saturated = 1'b1;
         end
         comp[i] = neg ? 32'(-quo) : 32'(quo);
      end
      res.force_x = comp[0];
      res.force_y = comp[1];
      res.force_z = comp[2];
      return res;
   endfunction

   task automatic take_vertex(input logic [287:0] d, input logic first);
      longint p [3];
      longint r [3];
      longint v [3];
      longint e [3];
      longint re [3];
      longint dv [3];
      for (int i = 0; i < 3; i++) begin
         p[i] = longint'($signed(d[32*i +: 32]));
         r[i] = longint'($signed(d[96 + 32*i +: 32]));
         v[i] = longint'($signed(d[192 + 32*i +: 32]));
      end
      if (first || !have_last) begin
         last_pos = p;
         last_rest = r;
         last_vel = v;
         have_last = 1'b1;
         edge_count = 0;
      end else if (edge_count < EdgeLimit) begin
         // rod still short enough: one edge force
         for (int i = 0; i < 3; i++) begin
            e[i] = p[i] - last_pos[i];
            re[i] = r[i] - last_rest[i];
            dv[i] = v[i] - last_vel[i];
         end
         force_queue = {force_queue, edge_force(e, re, dv, edge_count[9:0])};
         last_pos = p;
         last_rest = r;
         last_vel = v;
         edge_count++;
      end
   endtask

   task automatic check_force(input logic [111:0] d, input logic [1:0] u);
      edge_rsp_type want;
      if (force_queue.size() == 0) begin
         $error("response with no request pending");
         fail_count++;
         return;
      end
      want = force_queue.pop_front();
      if (d[31:0] !== want.force_x) begin
         $error("force_x expected %h actual %h", want.force_x, d[31:0]);
         fail_count++;
      end
      if (d[63:32] !== want.force_y) begin
         $error("force_y expected %h actual %h", want.force_y, d[63:32]);
         fail_count++;
      end
      if (d[95:64] !== want.force_z) begin
         $error("force_z expected %h actual %h", want.force_z, d[95:64]);
         fail_count++;
      end
      if (d[105:96] !== want.edge_index) begin
         $error("edge_index expected %0d actual %0d", want.edge_index, d[105:96]);
         fail_count++;
      end
      if (u[0] !== want.saturated) begin
         $error("saturated expected %b actual %b", want.saturated, u[0]);
         fail_count++;
      end
      if (u[1] !== want.zero_length) begin
         $error("zero_length expected %b actual %b", want.zero_length, u[1]);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stiffness = STIFFNESS_RESET;
         damping = 0;
         for (int i = 0; i < 3; i++) begin
            last_pos[i] = 0;
            last_rest[i] = 0;
            last_vel[i] = 0;
         end
         have_last = 1'b0;
         edge_count = 0;
         force_queue.delete();
         pending = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_STIFFNESS: stiffness = csr_wdata;
               CSR_DAMPING:   damping = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_vertex(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_force(rsp_tdata, rsp_tuser);
         pending = force_queue.size();
      end
   end

endmodule

[test/testbench.sv]
// testbench: stimulus and verdict for damped_edge_spring_force.
// Depends on desf_pkg, desf_checker and the block itself.
`timescale 1ns / 100ps

module testbench;
   import desf_pkg::*;

   // the cycle limit covers several slow runs over
   localparam int CycleLimit = 6_000_000;
   localparam int DrainWait  = 1000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [287:0]  req_tdata = '0;   // pos_x,pos_y,pos_z,rest_x..z,vel_x..z from bit 0
   logic          req_tuser = 1'b0; // first_vertex
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [111:0]  rsp_tdata;        // force_x,force_y,force_z,edge_index,pad from bit 0
   logic [1:0]    rsp_tuser;        // saturated, zero_length from bit 0
   logic          csr_wen = 1'b0;
   logic          csr_index = CSR_STIFFNESS;
   logic [31:0]   csr_wdata = '0;

   int            fail_count;
   int            pending;
   int            cycle_count = 0;
   bit            quiet = 1'b0;     // no idling on either side
   bit            hold_req = 1'b0;  // ask receiver for one long hold-off
   bit            hold_done = 1'b0; // long hold-off already given

   logic [31:0]   cur_pos [3];
   logic [31:0]   cur_rest [3];
   logic [31:0]   cur_vel [3];

   damped_edge_spring_force dut (.*);

   desf_checker checker_i (.*);

   initial forever #4 clock = ~clock;

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("damped_edge_spring_force regression: fail");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one vertex request; returns at the edge where it was taken
   task automatic send_vertex(input bit first);
      bit acc;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= first;
      req_tdata <= {cur_vel[2], cur_vel[1], cur_vel[0], cur_rest[2], cur_rest[1],
                    cur_rest[0], cur_pos[2], cur_pos[1], cur_pos[0]};
      do begin
         @(negedge clock);
         acc = req_tready;
         @(posedge clock);
      end while (!acc);
   endtask

   // drain, let the back end go quiet, then write both registers
   task automatic set_coeffs(input logic [31:0] k, input logic [31:0] c);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DrainWait) @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= CSR_STIFFNESS;
      csr_wdata <= k;
      @(posedge clock);
      csr_index <= CSR_DAMPING;
      csr_wdata <= c;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [31:0] walk(input logic [31:0] v);
      int w;
      int r;
      r = $urandom_range(0, 15);
      w = $urandom_range(1, 24);
      if (r == 0) return $urandom;
      if (r == 1) return v;
      return v + (($urandom % (32'd1 << w)) - (32'd1 << (w - 1)));
   endfunction

   task automatic set_all(input logic [31:0] p, input logic [31:0] r, input logic [31:0] v);
      for (int i = 0; i < 3; i++) begin
         cur_pos[i] = p;
         cur_rest[i] = r;
         cur_vel[i] = v;
      end
   endtask

   // random rod traffic: mostly walking vertices, some repeats and jumps
   task automatic random_rods(input int n, input int first_pct);
      bit still;
      for (int j = 0; j < n; j++) begin
         still = ($urandom_range(0, 11) == 0);
         for (int i = 0; i < 3; i++) begin
            if (!still) cur_pos[i] = walk(cur_pos[i]);
            cur_rest[i] = walk(cur_rest[i]);
            cur_vel[i] = ($urandom_range(0, 7) == 0) ? $urandom : walk(cur_vel[i]);
         end
         send_vertex($urandom_range(0, 99) < first_pct);
      end
   endtask

   initial begin
      set_all(0, 0, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients; first request without first_vertex starts a rod
      send_vertex(1'b0);
      send_vertex(1'b0);                       // zero-length edge
      cur_pos[0] = 32'h0001_0000;
      send_vertex(1'b0);                       // unit edge, stretched
      cur_vel[1] = 32'hFFFF_0000;
      cur_rest[2] = 32'h0000_8000;
      send_vertex(1'b0);
      set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_vertex(1'b1);
      set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_vertex(1'b0);                       // largest edge in every axis
      set_all(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
      send_vertex(1'b0);

      // saturation: stiffest spring, strongest damping
      set_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      set_all(0, 0, 0);
      send_vertex(1'b1);
      cur_pos[0] = 32'h4000_0000;
      cur_vel[0] = 32'h8000_0000;
      send_vertex(1'b0);
      cur_pos[1] = 32'h8000_0000;
      cur_rest[1] = 32'h7FFF_FFFF;
      send_vertex(1'b0);
      send_vertex(1'b0);                       // zero-length under high gain
      cur_pos[2] = 32'h0000_0001;
      send_vertex(1'b0);

      // no spring, damping only
      set_coeffs(32'h0000_0000, 32'h0001_0000);
      set_all(32'h0001_0000, 0, 32'h0002_0000);
      send_vertex(1'b1);
      cur_pos[0] = 32'h0003_0000;
      cur_vel[0] = 32'hFFFE_0000;
      send_vertex(1'b0);
      cur_pos[1] = 32'hFFFF_0000;
      send_vertex(1'b0);

      // long rod: runs past the edge limit, extra vertices are dropped
      set_coeffs(32'h0002_0000, 32'h0000_4000);
      send_vertex(1'b1);
      random_rods(EdgeLimit + 2, 0);
      send_vertex(1'b0);

      set_coeffs(STIFFNESS_RESET, 0);
      random_rods(150, 8);
      hold_req = 1'b1;                         // receiver backs up the queue
      random_rods(150, 8);
      set_coeffs($urandom, $urandom);
      random_rods(150, 8);
      set_coeffs(32'h0000_0001, 32'hFFFF_FFFF);
      random_rods(150, 8);
      set_coeffs($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000));
      random_rods(150, 8);
      set_coeffs($urandom, $urandom_range(0, 32'h0004_0000));
      quiet = 1'b1;
      random_rods(120, 8);

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DrainWait) @(posedge clock);
      if (fail_count == 0) begin
         $display("damped_edge_spring_force regression: pass");
      end else begin
         $display("damped_edge_spring_force regression: fail");
      end
      $finish;
   end

endmodule
